// File: rtl/bavgdec_pkg.sv
// ----------------------------------------------------------------------------
// bavgdec_pkg
// Shared types and constants for the block average decimator.
// ----------------------------------------------------------------------------
package bavgdec_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 20;
  localparam int COUNT_W  = 10;
  localparam int MEAN_W   = 10;
  localparam int CMD_W    = 2;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_SAMPLE = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_START  = 2'd2;

endpackage

// File: rtl/block_average_decimator_fifo.sv
// ----------------------------------------------------------------------------
// block_average_decimator_fifo
// Boxcar decimator that queues block means in a ring FIFO held in memory.
// ----------------------------------------------------------------------------
// The block accepts a new beat in each clock while its pipeline flows. A
// sample beat (command 0) adds its reading to the running sum; after
// BLOCK_LEN samples the sum travels down two pipeline registers, where a
// constant reciprocal multiplier forms the mean, and is then written into
// a FIFO_DEPTH entry memory with one write and one registered read port. A
// pop beat (command 1) reads the oldest mean and presents it on the output
// after stages a and b and the output register, with empty and sticky
// overflow flags in tuser. A start beat (command 2) clears the sum, the
// count, the FIFO and the overflow flag. While a result waits on the
// output, a pop beat stalls in stage b, and the input stalls once stage a
// also holds a beat. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module block_average_decimator_fifo
  import bavgdec_pkg::*;
#(
  parameter int BLOCK_LEN  = 900,
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] mean_value
  output logic [1:0]  out_tuser   // [0] empty_res, [1] overflowed
);

  localparam int PTR_W    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W   = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_SHIFT = SUM_W + $clog2(BLOCK_LEN);
  localparam int MULT_W   = SUM_W + 2;
  localparam int PROD_W   = SUM_W + MULT_W;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + BLOCK_LEN - 1) / BLOCK_LEN;

  // Running accumulation.
  logic [SUM_W-1:0]   sum_r, sum_nxt, sum_add;
  logic [COUNT_W-1:0] count_r, count_nxt, count_inc;

  // Pipeline stage a: command and finished block sum.
  logic               a_valid_r, a_valid_nxt, a_enter, a_go;
  cmd_t               a_cmd_r;
  logic [SUM_W-1:0]   a_sum_r;

  // Pipeline stage b: command and reciprocal product.
  logic               b_valid_r, b_valid_nxt, b_go;
  cmd_t               b_cmd_r;
  logic [PROD_W-1:0]  b_prod_r;
  logic [PROD_W-1:0]  b_quot;
  logic [MEAN_W-1:0]  b_mean;

  // FIFO control.
  logic [PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               drop_r, drop_nxt;
  logic               fifo_full, fifo_empty;
  logic               mem_we, mem_re;

  // Output stage.
  logic               out_valid_r, out_valid_nxt, out_free;
  logic               out_empty_r, out_ovf_r;
  logic [MEAN_W-1:0]  rd_data_r;

  logic               in_beat;
  cmd_t               in_cmd;

  logic [MEAN_W-1:0]  mem [FIFO_DEPTH];

  assign in_cmd    = cmd_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;
  assign b_go      = b_valid_r && ((b_cmd_r != CMD_POP) || out_free);
  assign a_go      = a_valid_r && (!b_valid_r || b_go);
  assign in_tready = !a_valid_r || a_go;
  assign in_beat   = in_tvalid && in_tready;

  assign sum_add   = sum_r + SUM_W'(in_tdata[SAMPLE_W-1:0]);
  assign count_inc = count_r + COUNT_W'(1);

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    a_enter   = 1'b0;
    if (in_beat) begin
      case (in_cmd)
        CMD_SAMPLE: begin
          if (count_inc >= COUNT_W'(BLOCK_LEN)) begin
            sum_nxt   = '0;
            count_nxt = '0;
            a_enter   = 1'b1;
          end else begin
            sum_nxt   = sum_add;
            count_nxt = count_inc;
          end
        end
        CMD_POP: begin
          a_enter = 1'b1;
        end
        CMD_START: begin
          sum_nxt   = '0;
          count_nxt = '0;
          a_enter   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign a_valid_nxt = in_beat ? a_enter : (a_go ? 1'b0 : a_valid_r);
  assign b_valid_nxt = a_go ? 1'b1 : (b_go ? 1'b0 : b_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      count_r   <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      a_cmd_r <= in_cmd;
      a_sum_r <= sum_add;
    end
    if (a_go) begin
      b_cmd_r  <= a_cmd_r;
      b_prod_r <= PROD_W'(a_sum_r) * PROD_W'(MULT_W'(DIV_MULT));
    end
  end

  // The reciprocal is rounded up with enough fraction bits that the
  // truncated product equals the exact quotient for every 20-bit sum.
  assign b_quot = b_prod_r >> DIV_SHIFT;
  assign b_mean = (b_quot > PROD_W'(MEAN_MAX)) ? MEAN_MAX : b_quot[MEAN_W-1:0];

  assign fifo_full  = (fill_r == FILL_W'(FIFO_DEPTH));
  assign fifo_empty = (fill_r == '0);

  always_comb begin
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (b_go) begin
      case (b_cmd_r)
        CMD_SAMPLE: begin
          if (fifo_full) begin
            drop_nxt = 1'b1;
          end else begin
            mem_we   = 1'b1;
            wptr_nxt = (wptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
            fill_nxt = fill_r + FILL_W'(1);
          end
        end
        CMD_POP: begin
          out_valid_nxt = 1'b1;
          if (!fifo_empty) begin
            mem_re   = 1'b1;
            rptr_nxt = (rptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
            fill_nxt = fill_r - FILL_W'(1);
          end
        end
        CMD_START: begin
          wptr_nxt = '0;
          rptr_nxt = '0;
          fill_nxt = '0;
          drop_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Flags of a pop beat; the overflow flag is sampled before this pop.
  always_ff @(posedge clk) begin
    if (b_go && (b_cmd_r == CMD_POP)) begin
      out_empty_r <= fifo_empty;
      out_ovf_r   <= drop_r;
    end
  end

  // Mean storage: one write port, one registered read port. A read of an
  // entry always comes in a later cycle than the write to that entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= b_mean;
    end
    if (mem_re) begin
      rd_data_r <= mem[rptr_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(16 - MEAN_W)'(0), (out_empty_r ? '0 : rd_data_r)};
  assign out_tuser  = {out_ovf_r, out_empty_r};

endmodule
